// File: hdl/tccf_pkg.sv
// tccf_pkg: shared types, cost codes, register indexes and merge helpers
// for the terrain cell cost fuser; no dependencies
package tccf_pkg;

  // cost codes of the costmap
  localparam logic [7:0] COST_UNKNOWN   = 8'd255;
  localparam logic [7:0] COST_LETHAL    = 8'd254;
  localparam logic [7:0] COST_INSCRIBED = 8'd253;
  localparam logic [7:0] COST_MAX_FREE  = 8'd252;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LETHAL_LEVEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSCRIBED_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_LEVEL        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_PENALTY_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_MODE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_ENABLE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_ENABLE      = 3'd7;

  localparam int unsigned CFG_DATA_W = 17;

  // unknown policy modes
  localparam logic [1:0] UNK_KEEP      = 2'd0;
  localparam logic [1:0] UNK_LETHAL    = 2'd1;
  localparam logic [1:0] UNK_INSCRIBED = 2'd2;
  localparam logic [1:0] UNK_NO_INFO   = 2'd3;

  typedef enum logic [1:0] {
    OUT_UNKNOWN = 2'd0,
    OUT_DROP    = 2'd1,
    OUT_TRAV    = 2'd2,
    OUT_BYPASS  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    TRAV_LETHAL    = 2'd0,
    TRAV_INSCRIBED = 2'd1,
    TRAV_FREE      = 2'd2
  } trav_class_t;

  // decision of one cell, carried down the pipeline
  typedef struct packed {
    outcome_t    outcome;
    trav_class_t tclass;
    logic        climb_use;
    logic [7:0]  prev_cost;
  } ctl_t;

  function automatic logic [7:0] merge_cost(input logic [7:0] prev_cost,
                                            input logic [7:0] target);
    logic [7:0] res;
    if (prev_cost == COST_UNKNOWN) begin
      res = target;
    end else if (prev_cost > target) begin
      res = prev_cost;
    end else begin
      res = target;
    end
    return res;
  endfunction

  function automatic logic [7:0] unk_mode_cost(input logic [1:0] mode,
                                               input logic [7:0] prev_cost);
    logic [7:0] res;
    unique case (mode)
      UNK_LETHAL:    res = merge_cost(prev_cost, COST_LETHAL);
      UNK_INSCRIBED: res = merge_cost(prev_cost, COST_INSCRIBED);
      UNK_NO_INFO:   res = COST_UNKNOWN;
      default:       res = prev_cost;
    endcase
    return res;
  endfunction

endpackage

// File: hdl/terrain_cell_cost_fuser.sv
// terrain_cell_cost_fuser: fuses terrain samples of one costmap cell into its new cost
// depends on tccf_pkg and tccf_scale
// out_valid rises once a request has passed the stage 1, stage 2 and output registers
// throughput: one request per cycle while busy is low, set by the three-stage pipeline with no feedback
// the receiver cannot stall, so busy is registered and falls once reset is released
// reset (rst_n low, synchronous): pipeline emptied, busy high, registers to defaults
module terrain_cell_cost_fuser #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        in_prev_cost,
  input  logic                              in_fresh_ok,
  input  logic signed [17:0]                in_fresh_value,
  input  logic                              in_drop_ok,
  input  logic signed [17:0]                in_drop_value,
  input  logic                              in_trav_ok,
  input  logic signed [17:0]                in_trav_value,
  input  logic                              in_climb_ok,
  input  logic signed [17:0]                in_climb_value,
  // result channel
  output logic                              out_valid,
  output logic [7:0]                        out_new_cost,
  output logic [1:0]                        out_outcome,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [tccf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tccf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // compare width: holds any sample and 1.0 with a sign bit
  localparam int CW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
  // unit width: 0..1.0
  localparam int TW = FRAC_BITS + 1;
  localparam logic signed [CW-1:0] OneQ  = CW'(64'd1 << FRAC_BITS);
  localparam logic signed [CW-1:0] HalfQ = CW'(64'd1 << (FRAC_BITS - 1));

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic        layer_enable_r;
  logic [16:0] lethal_level_r;
  logic [16:0] inscribed_level_r;
  logic [16:0] drop_level_r;
  logic [7:0]  climb_penalty_max_r;
  logic [1:0]  unknown_mode_r;
  logic        drop_enable_r;
  logic        climb_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_enable_r      <= 1'b1;
      lethal_level_r      <= 17'd13107;
      inscribed_level_r   <= 17'd26214;
      drop_level_r        <= 17'd39322;
      climb_penalty_max_r <= 8'd0;
      unknown_mode_r      <= tccf_pkg::UNK_KEEP;
      drop_enable_r       <= 1'b0;
      climb_enable_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tccf_pkg::CFG_LAYER_ENABLE:      layer_enable_r      <= cfg_data[0];
        tccf_pkg::CFG_LETHAL_LEVEL:      lethal_level_r      <= cfg_data;
        tccf_pkg::CFG_INSCRIBED_LEVEL:   inscribed_level_r   <= cfg_data;
        tccf_pkg::CFG_DROP_LEVEL:        drop_level_r        <= cfg_data;
        tccf_pkg::CFG_CLIMB_PENALTY_MAX: climb_penalty_max_r <= cfg_data[7:0];
        tccf_pkg::CFG_UNKNOWN_MODE:      unknown_mode_r      <= cfg_data[1:0];
        tccf_pkg::CFG_DROP_ENABLE:       drop_enable_r       <= cfg_data[0];
        tccf_pkg::CFG_CLIMB_ENABLE:      climb_enable_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // levels clamped to 1.0, threshold pair put in order, penalty capped
  logic signed [CW-1:0] lv_raw, iv_raw, dv_raw;
  logic signed [CW-1:0] lv_c, iv_c, dv_c;
  logic signed [CW-1:0] lo_lvl, hi_lvl;
  logic [7:0]           pmax;

  always_comb begin
    lv_raw = CW'(lethal_level_r);
    iv_raw = CW'(inscribed_level_r);
    dv_raw = CW'(drop_level_r);
    lv_c   = (lv_raw > OneQ) ? OneQ : lv_raw;
    iv_c   = (iv_raw > OneQ) ? OneQ : iv_raw;
    dv_c   = (dv_raw > OneQ) ? OneQ : dv_raw;
    lo_lvl = (lv_c < iv_c) ? lv_c : iv_c;
    hi_lvl = (lv_c < iv_c) ? iv_c : lv_c;
    pmax   = (climb_penalty_max_r > tccf_pkg::COST_MAX_FREE) ?
             tccf_pkg::COST_MAX_FREE : climb_penalty_max_r;
  end

  // no backpressure: only reset holds requests off
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // ---------------------------------------------------------------
  // stage 1: classify the cell, clamp the unit samples
  // ---------------------------------------------------------------
  logic signed [CW-1:0] fresh_x, drop_x, trav_x, climb_x;
  logic signed [CW-1:0] trav_c, climb_c;
  logic                 drop_hit;
  tccf_pkg::ctl_t       s1_ctl_nxt;
  logic [TW-1:0]        s1_free_nxt;
  logic [TW-1:0]        s1_climb_nxt;

  always_comb begin
    fresh_x = CW'(in_fresh_value);
    drop_x  = CW'(in_drop_value);
    trav_x  = CW'(in_trav_value);
    climb_x = CW'(in_climb_value);

    if (trav_x < 0) begin
      trav_c = '0;
    end else if (trav_x > OneQ) begin
      trav_c = OneQ;
    end else begin
      trav_c = trav_x;
    end

    if (climb_x < 0) begin
      climb_c = '0;
    end else if (climb_x > OneQ) begin
      climb_c = OneQ;
    end else begin
      climb_c = climb_x;
    end

    drop_hit = drop_enable_r && in_drop_ok && (drop_x >= dv_c);

    // decision order: bypass, stale, drop, missing traversability, cost
    if (!layer_enable_r) begin
      s1_ctl_nxt.outcome = tccf_pkg::OUT_BYPASS;
    end else if (!in_fresh_ok || (fresh_x < HalfQ)) begin
      s1_ctl_nxt.outcome = tccf_pkg::OUT_UNKNOWN;
    end else if (drop_hit) begin
      s1_ctl_nxt.outcome = tccf_pkg::OUT_DROP;
    end else if (!in_trav_ok) begin
      s1_ctl_nxt.outcome = tccf_pkg::OUT_UNKNOWN;
    end else begin
      s1_ctl_nxt.outcome = tccf_pkg::OUT_TRAV;
    end

    if (trav_c <= lo_lvl) begin
      s1_ctl_nxt.tclass = tccf_pkg::TRAV_LETHAL;
    end else if (trav_c <= hi_lvl) begin
      s1_ctl_nxt.tclass = tccf_pkg::TRAV_INSCRIBED;
    end else begin
      s1_ctl_nxt.tclass = tccf_pkg::TRAV_FREE;
    end

    s1_ctl_nxt.climb_use = climb_enable_r && in_climb_ok;
    s1_ctl_nxt.prev_cost = in_prev_cost;

    s1_free_nxt  = TW'(OneQ - trav_c);
    s1_climb_nxt = TW'(climb_c);
  end

  logic           s1_valid_r;
  tccf_pkg::ctl_t s1_ctl_r;
  logic [TW-1:0]  s1_free_r;
  logic [TW-1:0]  s1_climb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r   <= s1_ctl_nxt;
    s1_free_r  <= s1_free_nxt;
    s1_climb_r <= s1_climb_nxt;
  end

  // ---------------------------------------------------------------
  // stage 2: scale (1-t) to cost units and climbability to penalty
  // ---------------------------------------------------------------
  logic [7:0]     free_cost_r;
  logic [7:0]     penalty_r;
  logic           s2_valid_r;
  tccf_pkg::ctl_t s2_ctl_r;

  tccf_scale #(.FRAC_BITS(FRAC_BITS)) u_free_scale (
    .clk    (clk),
    .num    (s1_free_r),
    .factor (tccf_pkg::COST_MAX_FREE),
    .res_r  (free_cost_r)
  );

  tccf_scale #(.FRAC_BITS(FRAC_BITS)) u_climb_scale (
    .clk    (clk),
    .num    (s1_climb_r),
    .factor (pmax),
    .res_r  (penalty_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl_r <= s1_ctl_r;
  end

  // ---------------------------------------------------------------
  // stage 3: target cost, climb penalty, merge with the old cost
  // ---------------------------------------------------------------
  logic [7:0] target;
  logic [8:0] pen_sum;
  logic [7:0] cost_nxt;

  always_comb begin
    case (s2_ctl_r.tclass)
      tccf_pkg::TRAV_LETHAL:    target = tccf_pkg::COST_LETHAL;
      tccf_pkg::TRAV_INSCRIBED: target = tccf_pkg::COST_INSCRIBED;
      default: begin
        target = (free_cost_r > tccf_pkg::COST_MAX_FREE) ?
                 tccf_pkg::COST_MAX_FREE : free_cost_r;
      end
    endcase

    pen_sum = 9'(target) + 9'(penalty_r);
    // penalty only on free cells, saturating at the highest free cost
    if (s2_ctl_r.climb_use && (target < tccf_pkg::COST_INSCRIBED)) begin
      target = (pen_sum > 9'(tccf_pkg::COST_MAX_FREE)) ?
               tccf_pkg::COST_MAX_FREE : pen_sum[7:0];
    end

    case (s2_ctl_r.outcome)
      tccf_pkg::OUT_BYPASS: cost_nxt = s2_ctl_r.prev_cost;
      tccf_pkg::OUT_UNKNOWN: begin
        cost_nxt = tccf_pkg::unk_mode_cost(unknown_mode_r, s2_ctl_r.prev_cost);
      end
      tccf_pkg::OUT_DROP: begin
        cost_nxt = tccf_pkg::merge_cost(s2_ctl_r.prev_cost, tccf_pkg::COST_LETHAL);
      end
      default: cost_nxt = tccf_pkg::merge_cost(s2_ctl_r.prev_cost, target);
    endcase
  end

  logic               out_valid_r;
  logic [7:0]         out_new_cost_r;
  tccf_pkg::outcome_t out_outcome_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_new_cost_r <= cost_nxt;
    out_outcome_r  <= s2_ctl_r.outcome;
  end

  assign out_valid    = out_valid_r;
  assign out_new_cost = out_new_cost_r;
  assign out_outcome  = out_outcome_r;

`ifndef SYNTHESIS
  // every request in stage 1 reaches stage 2 on the next edge
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> s2_valid_r)
    else $error("request lost between stage 1 and stage 2");

  // rounded free cost never passes the highest free cost
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (free_cost_r <= tccf_pkg::COST_MAX_FREE))
    else $error("free cost out of range");

  // a drop hit always gives lethal or higher
  a_drop_lethal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_outcome_r == tccf_pkg::OUT_DROP)) |->
    (out_new_cost_r >= tccf_pkg::COST_LETHAL))
    else $error("drop outcome below lethal");

  // a traversability cost never leaves the cell unknown
  a_trav_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_outcome_r == tccf_pkg::OUT_TRAV)) |->
    (out_new_cost_r != tccf_pkg::COST_UNKNOWN))
    else $error("traversability outcome gave unknown cost");
`endif

endmodule

// File: hdl/tccf_scale.sv
// tccf_scale: registered round-half-up of num * factor / 2^FRAC_BITS
// num lies in 0..1.0; uses no package
module tccf_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   num,
  input  logic [7:0]           factor,
  output logic [7:0]           res_r
);

  localparam int PW = FRAC_BITS + 10;

  logic [PW-1:0] prod;
  logic [PW-1:0] rounded;
  logic [7:0]    res_nxt;

  assign prod    = PW'(num) * PW'(factor);
  assign rounded = prod + (PW'(1) << (FRAC_BITS - 1));
  assign res_nxt = rounded[FRAC_BITS+7:FRAC_BITS];

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: sim/tb.sv
// tb: self-checking bench for terrain_cell_cost_fuser, driving cell requests and
// register writes and comparing each strobed result with a local cost predictor
// depends on tccf_pkg and the terrain_cell_cost_fuser rtl
module tb;

  localparam int FRAC_BITS    = 16;
  localparam int ONE_Q        = 1 << FRAC_BITS;
  localparam int HALF_Q       = ONE_Q / 2;
  localparam int PIPE_LATENCY = 3;
  localparam int STALL_LIMIT  = 500;
  localparam int PHASE_CELLS  = 80;
  localparam int NUM_PHASES   = 8;
  localparam int IDX_W        = tccf_pkg::CFG_IDX_W;
  localparam int DATA_W       = tccf_pkg::CFG_DATA_W;

  // one cell request as it goes into the block
  typedef struct {
    logic [7:0]         prev_cost;
    logic               fresh_ok;
    logic signed [17:0] fresh_value;
    logic               drop_ok;
    logic signed [17:0] drop_value;
    logic               trav_ok;
    logic signed [17:0] trav_value;
    logic               climb_ok;
    logic signed [17:0] climb_value;
  } cell_t;

  // register file as the bench sees it
  typedef struct {
    bit        layer_en;
    bit [16:0] lethal_lvl;
    bit [16:0] inscribed_lvl;
    bit [16:0] drop_lvl;
    bit [7:0]  pen_max;
    bit [1:0]  unk_mode;
    bit        drop_en;
    bit        climb_en;
  } fuser_cfg_t;

  typedef struct {
    logic [7:0]         new_cost;
    tccf_pkg::outcome_t outcome;
  } cost_result_t;

  // predicts the fused cost of each accepted cell and checks the strobed results
  class cell_cost_scoreboard;
    fuser_cfg_t   cfg;
    cost_result_t expected_costs[$];
    int           failures;

    function new();
      cfg.layer_en      = 1'b1;
      cfg.lethal_lvl    = 17'd13107;
      cfg.inscribed_lvl = 17'd26214;
      cfg.drop_lvl      = 17'd39322;
      cfg.pen_max       = 8'd0;
      cfg.unk_mode      = tccf_pkg::UNK_KEEP;
      cfg.drop_en       = 1'b0;
      cfg.climb_en      = 1'b0;
      failures          = 0;
    endfunction

    function int clamp_q(input int v);
      if (v < 0) return 0;
      if (v > ONE_Q) return ONE_Q;
      return v;
    endfunction

    // (num * scale) / one, rounded half up
    function int round_scaled(input int num, input int scale);
      longint p;
      p = longint'(num) * scale;
      return int'((p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function logic [7:0] take_max_cost(input logic [7:0] prev_cost,
                                       input logic [7:0] target);
      if (prev_cost == tccf_pkg::COST_UNKNOWN) return target;
      return (prev_cost > target) ? prev_cost : target;
    endfunction

    function logic [7:0] apply_unknown(input logic [7:0] prev_cost);
      unique case (cfg.unk_mode)
        tccf_pkg::UNK_LETHAL:    return take_max_cost(prev_cost, tccf_pkg::COST_LETHAL);
        tccf_pkg::UNK_INSCRIBED: return take_max_cost(prev_cost, tccf_pkg::COST_INSCRIBED);
        tccf_pkg::UNK_NO_INFO:   return tccf_pkg::COST_UNKNOWN;
        default:                 return prev_cost;
      endcase
    endfunction

    function cost_result_t predict_cost(input cell_t c);
      cost_result_t r;
      int lvl_a, lvl_b, lo, hi, drop_q, trav_q, pen, target;
      lvl_a = clamp_q(int'(cfg.lethal_lvl));
      lvl_b = clamp_q(int'(cfg.inscribed_lvl));
      lo = (lvl_a < lvl_b) ? lvl_a : lvl_b;
      hi = (lvl_a < lvl_b) ? lvl_b : lvl_a;
      drop_q = clamp_q(int'(cfg.drop_lvl));
      pen = (cfg.pen_max > tccf_pkg::COST_MAX_FREE) ? int'(tccf_pkg::COST_MAX_FREE) :
            int'(cfg.pen_max);
      if (!cfg.layer_en) begin
        r.new_cost = c.prev_cost;
        r.outcome  = tccf_pkg::OUT_BYPASS;
      end else if (!c.fresh_ok || int'(c.fresh_value) < HALF_Q) begin
        r.new_cost = apply_unknown(c.prev_cost);
        r.outcome  = tccf_pkg::OUT_UNKNOWN;
      end else if (cfg.drop_en && c.drop_ok && int'(c.drop_value) >= drop_q) begin
        r.new_cost = take_max_cost(c.prev_cost, tccf_pkg::COST_LETHAL);
        r.outcome  = tccf_pkg::OUT_DROP;
      end else if (!c.trav_ok) begin
        r.new_cost = apply_unknown(c.prev_cost);
        r.outcome  = tccf_pkg::OUT_UNKNOWN;
      end else begin
        trav_q = clamp_q(int'(c.trav_value));
        if (trav_q <= lo) begin
          target = int'(tccf_pkg::COST_LETHAL);
        end else if (trav_q <= hi) begin
          target = int'(tccf_pkg::COST_INSCRIBED);
        end else begin
          target = round_scaled(ONE_Q - trav_q, int'(tccf_pkg::COST_MAX_FREE));
          if (target > int'(tccf_pkg::COST_MAX_FREE)) target = int'(tccf_pkg::COST_MAX_FREE);
        end
        if (cfg.climb_en && c.climb_ok && target < int'(tccf_pkg::COST_INSCRIBED)) begin
          target = target + round_scaled(clamp_q(int'(c.climb_value)), pen);
          if (target > int'(tccf_pkg::COST_MAX_FREE)) target = int'(tccf_pkg::COST_MAX_FREE);
        end
        r.new_cost = take_max_cost(c.prev_cost, target[7:0]);
        r.outcome  = tccf_pkg::OUT_TRAV;
      end
      return r;
    endfunction

    function void note_request(input cell_t c);
      expected_costs.push_back(predict_cost(c));
    endfunction

    function void check_result(input logic [7:0] new_cost, input logic [1:0] outcome);
      cost_result_t exp_r;
      if (expected_costs.size() == 0) begin
        $error("result with no request pending: new_cost=%0d outcome=%0d", new_cost, outcome);
        failures++;
        return;
      end
      exp_r = expected_costs.pop_front();
      if (new_cost !== exp_r.new_cost) begin
        $error("new_cost: expected %0d, actual %0d", exp_r.new_cost, new_cost);
        failures++;
      end
      if (outcome !== 2'(exp_r.outcome)) begin
        $error("outcome: expected %0d, actual %0d", exp_r.outcome, outcome);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_costs.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         in_prev_cost = '0;
  logic               in_fresh_ok = 1'b0;
  logic signed [17:0] in_fresh_value = '0;
  logic               in_drop_ok = 1'b0;
  logic signed [17:0] in_drop_value = '0;
  logic               in_trav_ok = 1'b0;
  logic signed [17:0] in_trav_value = '0;
  logic               in_climb_ok = 1'b0;
  logic signed [17:0] in_climb_value = '0;
  logic               out_valid;
  logic [7:0]         out_new_cost;
  logic [1:0]         out_outcome;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data = '0;

  cell_cost_scoreboard sb;
  fuser_cfg_t          phase_cfg[NUM_PHASES];
  int                  gap_pct[NUM_PHASES] = '{30, 0, 50, 25, 30, 60, 20, 0};
  int                  stall_cycles;

  terrain_cell_cost_fuser #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_prev_cost   (in_prev_cost),
    .in_fresh_ok    (in_fresh_ok),
    .in_fresh_value (in_fresh_value),
    .in_drop_ok     (in_drop_ok),
    .in_drop_value  (in_drop_value),
    .in_trav_ok     (in_trav_ok),
    .in_trav_value  (in_trav_value),
    .in_climb_ok    (in_climb_ok),
    .in_climb_value (in_climb_value),
    .out_valid      (out_valid),
    .out_new_cost   (out_new_cost),
    .out_outcome    (out_outcome),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // results cannot be held off, so every strobe is checked at the edge ending it
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_new_cost, out_outcome);
    end
  end

  // any random 18-bit pattern, negative ones included
  function automatic logic signed [17:0] rand18();
    return 18'($urandom_range(0, 18'h3FFFF));
  endfunction

  function automatic int clamp_unit(input int v);
    return (v < 0) ? 0 : ((v > ONE_Q) ? ONE_Q : v);
  endfunction

  function automatic cell_t make_cell(input int prev_cost, input int fok, input int fv,
                                      input int dok, input int dv, input int tok,
                                      input int tv, input int cok, input int cv);
    cell_t c;
    c.prev_cost   = 8'(prev_cost);
    c.fresh_ok    = (fok != 0);
    c.fresh_value = 18'(fv);
    c.drop_ok     = (dok != 0);
    c.drop_value  = 18'(dv);
    c.trav_ok     = (tok != 0);
    c.trav_value  = 18'(tv);
    c.climb_ok    = (cok != 0);
    c.climb_value = 18'(cv);
    return c;
  endfunction

  // mostly fresh cells, samples partly near the current levels, partly in range, the rest noise
  function automatic cell_t gen_cell();
    cell_t c;
    int    la, lb, lvl;
    int    sel;
    la = clamp_unit(int'(sb.cfg.lethal_lvl));
    lb = clamp_unit(int'(sb.cfg.inscribed_lvl));
    sel = $urandom_range(0, 7);
    case (sel)
      0:       c.prev_cost = tccf_pkg::COST_UNKNOWN;
      1:       c.prev_cost = 8'($urandom_range(tccf_pkg::COST_MAX_FREE, tccf_pkg::COST_LETHAL));
      default: c.prev_cost = 8'($urandom_range(0, 255));
    endcase
    c.fresh_ok = ($urandom_range(0, 9) != 0);
    sel = $urandom_range(0, 9);
    if (sel < 8) c.fresh_value = 18'($urandom_range(HALF_Q, 131071));
    else if (sel == 8) c.fresh_value = 18'(HALF_Q - 1 + int'($urandom_range(0, 1)));
    else c.fresh_value = rand18();
    c.drop_ok = ($urandom_range(0, 4) != 0);
    sel = $urandom_range(0, 3);
    if (sel < 2) begin
      c.drop_value = 18'(clamp_unit(int'(sb.cfg.drop_lvl)) + int'($urandom_range(0, 2)) - 1);
    end else if (sel == 2) begin
      c.drop_value = 18'($urandom_range(0, ONE_Q));
    end else begin
      c.drop_value = rand18();
    end
    c.trav_ok = ($urandom_range(0, 9) != 0);
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      lvl = $urandom_range(0, 1) ? la : lb;
      c.trav_value = 18'(lvl + int'($urandom_range(0, 2)) - 1);
    end else if (sel == 3) begin
      c.trav_value = rand18();
    end else begin
      c.trav_value = 18'($urandom_range(0, ONE_Q));
    end
    c.climb_ok = ($urandom_range(0, 4) != 0);
    c.climb_value = $urandom_range(0, 2) ? 18'($urandom_range(0, ONE_Q)) : rand18();
    return c;
  endfunction

  function automatic fuser_cfg_t gen_cfg();
    fuser_cfg_t k;
    k.layer_en      = ($urandom_range(0, 9) != 0);
    k.lethal_lvl    = $urandom_range(0, 3) ? 17'($urandom_range(0, ONE_Q)) : 17'($urandom);
    k.inscribed_lvl = $urandom_range(0, 3) ? 17'($urandom_range(0, ONE_Q)) : 17'($urandom);
    k.drop_lvl      = $urandom_range(0, 3) ? 17'($urandom_range(0, ONE_Q)) : 17'($urandom);
    k.pen_max       = 8'($urandom_range(0, 255));
    k.unk_mode      = 2'($urandom_range(0, 3));
    k.drop_en       = ($urandom_range(0, 3) != 0);
    k.climb_en      = ($urandom_range(0, 3) != 0);
    return k;
  endfunction

  task automatic drive_fields(input cell_t c);
    in_prev_cost   <= c.prev_cost;
    in_fresh_ok    <= c.fresh_ok;
    in_fresh_value <= c.fresh_value;
    in_drop_ok     <= c.drop_ok;
    in_drop_value  <= c.drop_value;
    in_trav_ok     <= c.trav_ok;
    in_trav_value  <= c.trav_value;
    in_climb_ok    <= c.climb_ok;
    in_climb_value <= c.climb_value;
  endtask

  // hold the request until the block takes it; start stays high on return
  task automatic send_cell(input cell_t c);
    drive_fields(c);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(c);
  endtask

  // sender idles with junk on the fields
  task automatic idle_gap(input int n);
    start <= 1'b0;
    drive_fields(gen_cell());
    repeat (n) @(posedge clk);
  endtask

  // stop requests and let every pending result come out
  task automatic drain_pipe();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    unique case (idx)
      tccf_pkg::CFG_LAYER_ENABLE:      sb.cfg.layer_en      = data[0];
      tccf_pkg::CFG_LETHAL_LEVEL:      sb.cfg.lethal_lvl    = data[16:0];
      tccf_pkg::CFG_INSCRIBED_LEVEL:   sb.cfg.inscribed_lvl = data[16:0];
      tccf_pkg::CFG_DROP_LEVEL:        sb.cfg.drop_lvl      = data[16:0];
      tccf_pkg::CFG_CLIMB_PENALTY_MAX: sb.cfg.pen_max       = data[7:0];
      tccf_pkg::CFG_UNKNOWN_MODE:      sb.cfg.unk_mode      = data[1:0];
      tccf_pkg::CFG_DROP_ENABLE:       sb.cfg.drop_en       = data[0];
      tccf_pkg::CFG_CLIMB_ENABLE:      sb.cfg.climb_en      = data[0];
      default: ;
    endcase
  endtask

  // registers change only with the pipeline empty
  task automatic load_settings(input fuser_cfg_t k);
    drain_pipe();
    write_reg(tccf_pkg::CFG_LAYER_ENABLE, DATA_W'(k.layer_en));
    write_reg(tccf_pkg::CFG_LETHAL_LEVEL, DATA_W'(k.lethal_lvl));
    write_reg(tccf_pkg::CFG_INSCRIBED_LEVEL, DATA_W'(k.inscribed_lvl));
    write_reg(tccf_pkg::CFG_DROP_LEVEL, DATA_W'(k.drop_lvl));
    write_reg(tccf_pkg::CFG_CLIMB_PENALTY_MAX, DATA_W'(k.pen_max));
    write_reg(tccf_pkg::CFG_UNKNOWN_MODE, DATA_W'(k.unk_mode));
    write_reg(tccf_pkg::CFG_DROP_ENABLE, DATA_W'(k.drop_en));
    write_reg(tccf_pkg::CFG_CLIMB_ENABLE, DATA_W'(k.climb_en));
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n, input int idle_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 6));
      send_cell(gen_cell());
    end
  endtask

  // watchdog: too long without any request or result taken ends the run
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    fuser_cfg_t dir_cfg;
    sb = new();

    // phase settings: all-low extremes, all-high with levels above one,
    // swapped level pair, bypass, then random ones
    phase_cfg[0] = '{1'b1, 17'd0, 17'd0, 17'd0, 8'd0, tccf_pkg::UNK_LETHAL, 1'b1, 1'b1};
    phase_cfg[1] = '{1'b1, 17'h1FFFF, 17'd65536, 17'h1FFFF, 8'd255, tccf_pkg::UNK_NO_INFO,
                     1'b1, 1'b1};
    phase_cfg[2] = '{1'b1, 17'd40000, 17'd10000, 17'd65536, 8'd252, tccf_pkg::UNK_INSCRIBED,
                     1'b1, 1'b1};
    phase_cfg[3] = gen_cfg();
    phase_cfg[3].layer_en = 1'b0;
    phase_cfg[4] = gen_cfg();
    phase_cfg[4].layer_en = 1'b1;
    phase_cfg[4].unk_mode = tccf_pkg::UNK_KEEP;
    phase_cfg[4].drop_en  = 1'b0;
    phase_cfg[4].climb_en = 1'b0;
    phase_cfg[5] = gen_cfg();
    phase_cfg[6] = gen_cfg();
    phase_cfg[7] = gen_cfg();
    phase_cfg[7].layer_en = 1'b1;

    // default levels, penalty large enough to saturate
    dir_cfg = '{1'b1, 17'd13107, 17'd26214, 17'd39322, 8'd200, tccf_pkg::UNK_INSCRIBED,
                1'b1, 1'b1};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    load_settings(dir_cfg);
    // freshness missing, just below half, exactly half
    send_cell(make_cell(10, 0, 65536, 1, 0, 1, 65536, 1, 0));
    send_cell(make_cell(255, 1, HALF_Q - 1, 0, 0, 1, 65536, 0, 0));
    send_cell(make_cell(0, 1, HALF_Q, 0, 0, 1, 65536, 0, 0));
    // freshness extremes
    send_cell(make_cell(0, 1, 131071, 0, 0, 1, 65536, 0, 0));
    send_cell(make_cell(0, 1, -131072, 0, 0, 1, 65536, 0, 0));
    // drop at its level, one below, sample missing, negative extreme
    send_cell(make_cell(255, 1, 65536, 1, 39322, 1, 65536, 0, 0));
    send_cell(make_cell(0, 1, 65536, 1, 39321, 1, 65536, 0, 0));
    send_cell(make_cell(0, 1, 65536, 0, 131071, 1, 65536, 0, 0));
    send_cell(make_cell(0, 1, 65536, 1, -131072, 1, 65536, 0, 0));
    // traversability missing with old cost above the policy target
    send_cell(make_cell(254, 1, 65536, 0, 0, 0, 65536, 0, 0));
    // traversability at and around both levels
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 13107, 0, 0));
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 13108, 0, 0));
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 26214, 0, 0));
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 26215, 0, 0));
    // traversability clamped from both ends
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, -131072, 1, 65536));
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 131071, 1, 32768));
    // climbable clamped high, negative, missing, and a saturating sum
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 32768, 1, 131071));
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 32768, 1, -131072));
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 32768, 0, 65536));
    send_cell(make_cell(0, 1, 65536, 0, 0, 1, 26215, 1, 65536));
    // merge with old cost: larger old kept, unknown old replaced
    send_cell(make_cell(253, 1, 65536, 0, 0, 1, 65536, 0, 0));
    send_cell(make_cell(255, 1, 65536, 0, 0, 1, 40000, 1, 20000));

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_settings(phase_cfg[p]);
      run_random(PHASE_CELLS, gap_pct[p]);
    end

    drain_pipe();
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tccf_pkg.sv
hdl/tccf_scale.sv
hdl/terrain_cell_cost_fuser.sv
sim/tb.sv
